// ===== sv/vcpi_pkg.sv =====
// Shared types and constants for the video chip port interface.
// Used by the front decode stage, the request queue and the execution back end.
package vcpi_pkg;

   localparam int MEM_DEPTH = 16384;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int ADDR_W    = 14;

   localparam int FIFO_AW    = 1;
   localparam int FIFO_DEPTH = 2 ** FIFO_AW;

   // Port operation codes as they arrive on the request channel
   localparam logic [2:0] OP_DATA_WR   = 3'd0;
   localparam logic [2:0] OP_CTRL_WR   = 3'd1;
   localparam logic [2:0] OP_DATA_RD   = 3'd2;
   localparam logic [2:0] OP_STATUS_RD = 3'd3;
   localparam logic [2:0] OP_FRAME_END = 3'd4;

   localparam int CTRL_REG_SEL_BIT = 7;
   localparam int NO_PREFETCH_BIT  = 6;
   localparam int IRQ_ENABLE_BIT   = 5;
   localparam int STATUS_FRAME_BIT = 7;
   localparam logic [7:0] STATUS_CLEAR_MASK = 8'h5F;
   localparam logic [2:0] IRQ_CTRL_REG = 3'd1;

   typedef enum logic [5:0] {
      KIND_NOP       = 6'b000001,
      KIND_DATA_WR   = 6'b000010,
      KIND_CTRL_WR   = 6'b000100,
      KIND_DATA_RD   = 6'b001000,
      KIND_STATUS_RD = 6'b010000,
      KIND_FRAME_END = 6'b100000
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [4:0]  sprite_number;
   } item_type;

   function automatic kind_type decode_op(input logic [2:0] op);
      kind_type k;
      unique case (op)
         OP_DATA_WR:   k = KIND_DATA_WR;
         OP_CTRL_WR:   k = KIND_CTRL_WR;
         OP_DATA_RD:   k = KIND_DATA_RD;
         OP_STATUS_RD: k = KIND_STATUS_RD;
         OP_FRAME_END: k = KIND_FRAME_END;
         default:      k = KIND_NOP;
      endcase
      return k;
   endfunction

endpackage

// ===== sv/video_chip_port_interface.sv =====
// An accepted request passes the decode register, then the queue, and is then
// executed into the response register.
// One request per cycle while the response channel is ready, except data reads
// and prefetching address loads, which hold the back end in the fill state
// while the single synchronous video memory port refills the read-ahead byte.
// Reset clears address, byte latch, read-ahead, control and status registers;
// video memory content is not cleared and no clearing pass is run.
module video_chip_port_interface
   import vcpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [12:8] sprite_number, [15:13] zero
   input  logic [2:0]  req_tuser,   // [2:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] read_data, [8] interrupt_request, [15:9] zero
);

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;
   logic [7:0] read_data;
   logic       interrupt_request;

   vcpi_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_op            (req_tuser),
      .req_data_byte     (req_tdata[7:0]),
      .req_sprite_number (req_tdata[12:8]),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_item         (push_item)
   );

   vcpi_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   vcpi_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .item_valid            (pop_valid),
      .item_ready            (pop_ready),
      .item                  (pop_item),
      .rsp_valid             (rsp_tvalid),
      .rsp_ready             (rsp_tready),
      .rsp_read_data         (read_data),
      .rsp_interrupt_request (interrupt_request)
   );

   assign rsp_tdata = {7'd0, interrupt_request, read_data};

endmodule

// ===== sv/vcpi_front.sv =====
// Front stage: accepts port requests, decodes the op code and holds one item.
// Depends on vcpi_pkg.
module vcpi_front
   import vcpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_data_byte,
   input  logic [4:0]  req_sprite_number,
   output logic        push_valid,
   input  logic        push_ready,
   output item_type    push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      valid_in = valid_ff && !push_ready;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in               = 1'b1;
         item_in.kind           = decode_op(req_op);
         item_in.data_byte      = req_data_byte;
         item_in.sprite_number  = req_sprite_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ===== sv/vcpi_fifo.sv =====
// Short request queue between the decode front and the execution back end.
// Depends on vcpi_pkg.
module vcpi_fifo
   import vcpi_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type             entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != (FIFO_AW+1)'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/vcpi_back.sv =====
// Execution back end: owns video memory, address, byte latch, control and
// status registers, and the registered response. Depends on vcpi_pkg.
module vcpi_back
   import vcpi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   output logic       item_ready,
   input  item_type   item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_interrupt_request
);

   typedef enum logic [1:0] {
      ST_EXEC = 2'b01,
      ST_FILL = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [7:0]         latch_ff, latch_in;
   logic               pending_ff, pending_in;
   logic [7:0]         read_ahead_ff, read_ahead_in;
   logic [7:0]         ctrl_ff [8];
   logic [7:0]         ctrl_in [8];
   logic [7:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic               rsp_irq_ff, rsp_irq_in;

   logic [7:0]         mem [MEM_DEPTH];
   logic [7:0]         mem_rdata_ff;
   logic               mem_we;
   logic [MEM_AW-1:0]  mem_addr;
   logic [ADDR_W-1:0]  load_addr;
   logic               take;

   assign item_ready            = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign take                  = item_valid && item_ready;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rsp_data_ff;
   assign rsp_interrupt_request = rsp_irq_ff;
   assign load_addr             = {item.data_byte[5:0], latch_ff};

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      latch_in      = latch_ff;
      pending_in    = pending_ff;
      read_ahead_in = read_ahead_ff;
      ctrl_in       = ctrl_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_irq_in    = rsp_irq_ff;
      mem_we        = 1'b0;
      mem_addr      = addr_ff[MEM_AW-1:0];

      if (state_ff == ST_FILL) begin
         // capture the refill byte read in the previous cycle
         read_ahead_in = mem_rdata_ff;
         state_in      = ST_EXEC;
      end else if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = 8'd0;
         rsp_irq_in   = 1'b0;
         unique case (item.kind)
            KIND_DATA_WR: begin
               mem_we        = 1'b1;
               read_ahead_in = item.data_byte;
               addr_in       = addr_ff + 1'b1;
               pending_in    = 1'b0;
            end
            KIND_CTRL_WR: begin
               if (pending_ff) begin
                  pending_in = 1'b0;
                  if (item.data_byte[CTRL_REG_SEL_BIT]) begin
                     ctrl_in[item.data_byte[2:0]] = latch_ff;
                     if (item.data_byte[2:0] == IRQ_CTRL_REG &&
                         latch_ff[IRQ_ENABLE_BIT] && status_ff[STATUS_FRAME_BIT]) begin
                        rsp_irq_in = 1'b1;
                     end
                  end else begin
                     addr_in = load_addr;
                     if (!item.data_byte[NO_PREFETCH_BIT]) begin
                        mem_addr = load_addr[MEM_AW-1:0];
                        addr_in  = load_addr + 1'b1;
                        state_in = ST_FILL;
                     end
                  end
               end else begin
                  latch_in   = item.data_byte;
                  pending_in = 1'b1;
               end
            end
            KIND_DATA_RD: begin
               rsp_data_in = read_ahead_ff;
               addr_in     = addr_ff + 1'b1;
               pending_in  = 1'b0;
               state_in    = ST_FILL;
            end
            KIND_STATUS_RD: begin
               rsp_data_in = status_ff;
               status_in   = status_ff & STATUS_CLEAR_MASK;
               pending_in  = 1'b0;
            end
            KIND_FRAME_END: begin
               status_in  = {1'b1, status_ff[6:5], item.sprite_number};
               rsp_irq_in = ctrl_ff[IRQ_CTRL_REG][IRQ_ENABLE_BIT];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_EXEC;
         addr_ff       <= '0;
         latch_ff      <= '0;
         pending_ff    <= 1'b0;
         read_ahead_ff <= '0;
         status_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            ctrl_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         latch_ff      <= latch_in;
         pending_ff    <= pending_in;
         read_ahead_ff <= read_ahead_in;
         status_ff     <= status_in;
         rsp_valid_ff  <= rsp_valid_in;
         ctrl_ff       <= ctrl_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_irq_ff  <= rsp_irq_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= item.data_byte;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

endmodule
